### src/m3i_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared constants and width helpers for the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package m3i_pkg;

  // Nine matrix elements per request, nine cofactor and divider lanes.
  localparam int NUM_ELEMS = 9;

  // Pipeline stage numbers (register stages, counted from the input register).
  localparam int ST_ABS  = 6;  // determinant magnitude and zero flag
  localparam int ST_DIV0 = 8;  // first divider stage

  // Cofactor: difference of two 2*ew products.
  function automatic int cof_width(input int ew);
    return 2 * ew + 1;
  endfunction

  // Determinant: sum of three element-by-cofactor products.
  function automatic int det_width(input int ew);
    return 3 * ew + 3;
  endfunction

  // Cofactor magnitude scaled by 2^(2*fb).
  function automatic int num_width(input int ew, input int fb);
    return 2 * ew + 1 + 2 * fb;
  endfunction

  // Divider remainder: holds 2|N|+|D| and 2|D| shifted by ew.
  function automatic int rem_width(input int ew, input int fb);
    int a;
    int b;
    a = num_width(ew, fb) + 2;
    b = det_width(ew) + ew + 1;
    return ((a > b) ? a : b) + 1;
  endfunction

  // Register stages up to and including the lane result register.
  function automatic int pipe_depth(input int ew);
    return ST_DIV0 + ew + 2;
  endfunction

endpackage

### src/matrix_3x3_inverse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_3x3_inverse
// Fixed-point 3x3 matrix inverse by the adjugate: nine cofactor lanes, a
// determinant merge and nine pipelined dividers, one matrix per cycle when not stalled.
// ----------------------------------------------------------------------------
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------
//   in      | in_valid / in_stall | in_r0c0 .. in_r2c2 (signed, Q format)
//   out     | out_valid/out_stall | out_r0c0 .. out_r2c2, singular
//
// - Accepts one request every cycle while in_stall is low. The restoring
//   dividers take one quotient bit per stage over ELEM_WIDTH+1 stages;
//   ahead of them sit eight stages of input, products, cofactors and
//   determinant, behind them one rounding stage and the output register.
// - rst is synchronous; it clears the pipeline valid bits and the output
//   and skid valid flags, payload registers keep whatever they hold.
// - A stalled result sits in the output register; one more result lands in
//   the skid register, and only then is the whole pipeline frozen and
//   in_stall raised.
// - A zero determinant gives all-zero entries with singular set.
//
module matrix_3x3_inverse #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [ELEM_WIDTH-1:0] in_r0c0,
  input  logic signed [ELEM_WIDTH-1:0] in_r0c1,
  input  logic signed [ELEM_WIDTH-1:0] in_r0c2,
  input  logic signed [ELEM_WIDTH-1:0] in_r1c0,
  input  logic signed [ELEM_WIDTH-1:0] in_r1c1,
  input  logic signed [ELEM_WIDTH-1:0] in_r1c2,
  input  logic signed [ELEM_WIDTH-1:0] in_r2c0,
  input  logic signed [ELEM_WIDTH-1:0] in_r2c1,
  input  logic signed [ELEM_WIDTH-1:0] in_r2c2,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [ELEM_WIDTH-1:0] out_r0c0,
  output logic signed [ELEM_WIDTH-1:0] out_r0c1,
  output logic signed [ELEM_WIDTH-1:0] out_r0c2,
  output logic signed [ELEM_WIDTH-1:0] out_r1c0,
  output logic signed [ELEM_WIDTH-1:0] out_r1c1,
  output logic signed [ELEM_WIDTH-1:0] out_r1c2,
  output logic signed [ELEM_WIDTH-1:0] out_r2c0,
  output logic signed [ELEM_WIDTH-1:0] out_r2c1,
  output logic signed [ELEM_WIDTH-1:0] out_r2c2,
  output logic                         singular
);

  localparam int EW = ELEM_WIDTH;
  localparam int NE = m3i_pkg::NUM_ELEMS;
  localparam int CW = m3i_pkg::cof_width(EW);
  localparam int DW = m3i_pkg::det_width(EW);
  localparam int NS = m3i_pkg::pipe_depth(EW);
  localparam int SA = m3i_pkg::ST_ABS;

  logic                 adv;          // whole pipeline advances
  logic [NS-1:0]        v;            // stage valid bits
  logic [NS-1:SA+1]     sng_d;        // singular flag follows the divider
  logic signed [EW-1:0] e_in [NE];
  logic signed [EW-1:0] e0   [NE];
  logic signed [EW-1:0] r0_1 [3];
  logic signed [EW-1:0] r0_2 [3];
  logic signed [CW-1:0] cof  [NE];
  logic [DW-1:0]        det_abs;
  logic                 det_neg;
  logic                 det_zero;
  logic [EW-1:0]        res  [NE];
  logic [EW-1:0]        inc  [NE];
  logic [EW-1:0]        obuf [NE];
  logic [EW-1:0]        skid [NE];
  logic                 obuf_sng;
  logic                 skid_sng;
  logic                 skid_valid;
  logic                 out_free;
  logic                 arrive;

  // Freeze everything only when the skid register is holding a result.
  assign adv      = !skid_valid;
  assign in_stall = skid_valid;

  assign e_in[0] = in_r0c0;
  assign e_in[1] = in_r0c1;
  assign e_in[2] = in_r0c2;
  assign e_in[3] = in_r1c0;
  assign e_in[4] = in_r1c1;
  assign e_in[5] = in_r1c2;
  assign e_in[6] = in_r2c0;
  assign e_in[7] = in_r2c1;
  assign e_in[8] = in_r2c2;

  // Capture the request; carry row 0 along to meet its cofactors.
  always_ff @(posedge clk) begin
    if (adv) begin
      e0    <= e_in;
      r0_1  <= e0[0:2];
      r0_2  <= r0_1;
      sng_d <= {sng_d[NS-2:SA+1], det_zero};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NS-2:0], in_valid};
    end
  end

  // Cofactor lanes: lane i*3+j holds the signed minor of row i, column j.
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int R0 = (i == 0) ? 1 : 0;
      localparam int R1 = (i == 2) ? 1 : 2;
      localparam int C0 = (j == 0) ? 1 : 0;
      localparam int C1 = (j == 2) ? 1 : 2;

      m3i_minor_lane #(
        .EW  (EW),
        .NEG (((i + j) % 2) == 1)
      ) u_minor (
        .clk (clk),
        .adv (adv),
        .a   (e0[R0*3+C0]),
        .b   (e0[R0*3+C1]),
        .c   (e0[R1*3+C0]),
        .d   (e0[R1*3+C1]),
        .cof (cof[i*3+j])
      );
    end
  end

  m3i_det_merge #(
    .EW (EW)
  ) u_det (
    .clk      (clk),
    .adv      (adv),
    .e0       (r0_2[0]),
    .e1       (r0_2[1]),
    .e2       (r0_2[2]),
    .c0       (cof[0]),
    .c1       (cof[1]),
    .c2       (cof[2]),
    .det_abs  (det_abs),
    .det_neg  (det_neg),
    .det_zero (det_zero)
  );

  // Divider lanes: output (i, j) divides the transposed cofactor (j, i).
  for (genvar i = 0; i < 3; i++) begin : g_orow
    for (genvar j = 0; j < 3; j++) begin : g_ocol
      m3i_div_lane #(
        .EW (EW),
        .FB (FRAC_BITS)
      ) u_div (
        .clk     (clk),
        .adv     (adv),
        .cof     (cof[j*3+i]),
        .det_abs (det_abs),
        .det_neg (det_neg),
        .res     (res[i*3+j])
      );
      // Drop the quotient when the matrix is singular.
      assign inc[i*3+j] = sng_d[NS-1] ? '0 : res[i*3+j];
    end
  end

  // Output register with a skid register behind it.
  assign out_free = !out_valid || !out_stall;
  assign arrive   = adv && v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || arrive;
      skid_valid <= 1'b0;
    end else if (arrive) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      obuf     <= skid_valid ? skid : inc;
      obuf_sng <= skid_valid ? skid_sng : sng_d[NS-1];
    end else if (adv) begin
      skid     <= inc;
      skid_sng <= sng_d[NS-1];
    end
  end

  assign out_r0c0 = obuf[0];
  assign out_r0c1 = obuf[1];
  assign out_r0c2 = obuf[2];
  assign out_r1c0 = obuf[3];
  assign out_r1c1 = obuf[4];
  assign out_r1c2 = obuf[5];
  assign out_r2c0 = obuf[6];
  assign out_r2c1 = obuf[7];
  assign out_r2c2 = obuf[8];
  assign singular = obuf_sng;

endmodule

### src/m3i_minor_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_minor_lane
// One cofactor lane: two products, then a signed difference (two stages).
// ----------------------------------------------------------------------------
module m3i_minor_lane #(
  parameter int EW  = 32,
  parameter bit NEG = 1'b0
) (
  input  logic                                        clk,
  input  logic                                        adv,
  input  logic signed [EW-1:0]                        a,
  input  logic signed [EW-1:0]                        b,
  input  logic signed [EW-1:0]                        c,
  input  logic signed [EW-1:0]                        d,
  output logic signed [m3i_pkg::cof_width(EW)-1:0]    cof
);

  localparam int CW = m3i_pkg::cof_width(EW);

  logic signed [2*EW-1:0] p_ad;
  logic signed [2*EW-1:0] p_cb;

  // Odd checkerboard positions swap the operands instead of negating.
  always_ff @(posedge clk) begin
    if (adv) begin
      p_ad <= a * d;
      p_cb <= c * b;
      cof  <= NEG ? (CW'(p_cb) - CW'(p_ad)) : (CW'(p_ad) - CW'(p_cb));
    end
  end

endmodule

### src/m3i_det_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_det_merge
// Merge row 0 with its cofactors into the determinant, its magnitude,
// sign and zero flag (four stages).
// ----------------------------------------------------------------------------
module m3i_det_merge #(
  parameter int EW = 32
) (
  input  logic                                        clk,
  input  logic                                        adv,
  input  logic signed [EW-1:0]                        e0,
  input  logic signed [EW-1:0]                        e1,
  input  logic signed [EW-1:0]                        e2,
  input  logic signed [m3i_pkg::cof_width(EW)-1:0]    c0,
  input  logic signed [m3i_pkg::cof_width(EW)-1:0]    c1,
  input  logic signed [m3i_pkg::cof_width(EW)-1:0]    c2,
  output logic        [m3i_pkg::det_width(EW)-1:0]    det_abs,
  output logic                                        det_neg,
  output logic                                        det_zero
);

  localparam int CW = m3i_pkg::cof_width(EW);
  localparam int DW = m3i_pkg::det_width(EW);
  localparam int PW = 2 * EW + 1;
  localparam int TW = 3 * EW + 2;

  logic signed [EW-1:0] ev [3];
  logic signed [CW-1:0] cv [3];
  logic signed [PW-1:0] p_lo [3];
  logic signed [PW-1:0] p_hi [3];
  logic signed [TW-1:0] term [3];
  logic signed [DW-1:0] det;

  assign ev[0] = e0;
  assign ev[1] = e1;
  assign ev[2] = e2;
  assign cv[0] = c0;
  assign cv[1] = c1;
  assign cv[2] = c2;

  // Split each cofactor into a low unsigned half and a high signed half so
  // that no multiplier is wider than EW by EW+1.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        p_lo[j] <= ev[j] * $signed({1'b0, cv[j][EW-1:0]});
        p_hi[j] <= ev[j] * $signed(cv[j][CW-1:EW]);
        term[j] <= (TW'(p_hi[j]) <<< EW) + TW'(p_lo[j]);
      end
      det      <= DW'(term[0]) + DW'(term[1]) + DW'(term[2]);
      det_abs  <= det[DW-1] ? ((~det) + DW'(1)) : det;
      det_neg  <= det[DW-1];
      det_zero <= (det == '0);
    end
  end

endmodule

### src/m3i_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_div_lane
// One output lane: scale the cofactor, divide by the determinant with a
// restoring divider of one quotient bit per stage, round and saturate.
// ----------------------------------------------------------------------------
module m3i_div_lane #(
  parameter int EW = 32,
  parameter int FB = 16
) (
  input  logic                                        clk,
  input  logic                                        adv,
  input  logic signed [m3i_pkg::cof_width(EW)-1:0]    cof,
  input  logic        [m3i_pkg::det_width(EW)-1:0]    det_abs,
  input  logic                                        det_neg,
  output logic        [EW-1:0]                        res
);

  localparam int CW = m3i_pkg::cof_width(EW);
  localparam int DW = m3i_pkg::det_width(EW);
  localparam int NW = m3i_pkg::num_width(EW, FB);
  localparam int RW = m3i_pkg::rem_width(EW, FB);
  localparam logic [EW:0]   HALF     = {2'b01, {(EW-1){1'b0}}};
  localparam logic [EW:0]   HALF_M1  = {2'b00, {(EW-1){1'b1}}};
  localparam logic [EW-1:0] SAT_POS  = {1'b0, {(EW-1){1'b1}}};
  localparam logic [EW-1:0] SAT_NEG  = {1'b1, {(EW-1){1'b0}}};

  // Hold the cofactor until the determinant is ready.
  logic signed [CW-1:0] c3;
  logic signed [CW-1:0] c4;
  logic signed [CW-1:0] c5;
  logic        [CW-1:0] c_mag;
  logic        [NW-1:0] n_abs;
  logic                 c_neg;

  logic [RW-1:0] rem_s [EW+1];
  logic [DW:0]   dd_s  [EW+1];
  logic [EW:0]   q_s   [EW+2];
  logic          neg_s [EW+2];

  assign c_mag = c5[CW-1] ? ((~c5) + CW'(1)) : c5;

  always_ff @(posedge clk) begin
    if (adv) begin
      c3       <= cof;
      c4       <= c3;
      c5       <= c4;
      n_abs    <= NW'(c_mag) << (2 * FB);
      c_neg    <= c5[CW-1];
      // round to nearest: (2|N| + |D|) / (2|D|)
      rem_s[0] <= (RW'(n_abs) << 1) + RW'(det_abs);
      dd_s[0]  <= {det_abs, 1'b0};
      q_s[0]   <= '0;
      neg_s[0] <= c_neg ^ det_neg;
    end
  end

  // Quotient bit EW set means the magnitude is at least 2^EW: saturate.
  for (genvar k = 0; k <= EW; k++) begin : g_div
    localparam int B = EW - k;
    logic [RW-1:0] dsh;
    logic          fits;

    assign dsh  = RW'(dd_s[k]) << B;
    assign fits = (rem_s[k] >= dsh);

    always_ff @(posedge clk) begin
      if (adv) begin
        q_s[k+1]   <= {q_s[k][EW-1:0], fits};
        neg_s[k+1] <= neg_s[k];
      end
    end

    if (k < EW) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_s[k+1] <= fits ? (rem_s[k] - dsh) : rem_s[k];
          dd_s[k+1]  <= dd_s[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (neg_s[EW+1]) begin
        res <= (q_s[EW+1] > HALF) ? SAT_NEG : ((~q_s[EW+1][EW-1:0]) + EW'(1));
      end else begin
        res <= (q_s[EW+1] > HALF_M1) ? SAT_POS : q_s[EW+1][EW-1:0];
      end
    end
  end

endmodule

### src/m3i_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_checker
// Port-level checks for the matrix inverse, bound to the top level.
// ----------------------------------------------------------------------------
module m3i_checker #(
  parameter int ELEM_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [ELEM_WIDTH-1:0] out_r0c0,
  input logic [ELEM_WIDTH-1:0] out_r0c1,
  input logic [ELEM_WIDTH-1:0] out_r0c2,
  input logic [ELEM_WIDTH-1:0] out_r1c0,
  input logic [ELEM_WIDTH-1:0] out_r1c1,
  input logic [ELEM_WIDTH-1:0] out_r1c2,
  input logic [ELEM_WIDTH-1:0] out_r2c0,
  input logic [ELEM_WIDTH-1:0] out_r2c1,
  input logic [ELEM_WIDTH-1:0] out_r2c2,
  input logic                  singular
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_r0c0) && $stable(out_r1c1)
                               && $stable(out_r2c2) && $stable(singular))
    else $error("stalled result changed");

  // A singular matrix reports all-zero entries.
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |->
      (out_r0c0 | out_r0c1 | out_r0c2 | out_r1c0 | out_r1c1 | out_r1c2 |
       out_r2c0 | out_r2c1 | out_r2c2) == '0)
    else $error("singular result with nonzero entry");

  // Input is held back only while a result is waiting at the output.
  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_stall_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall raised without output backpressure");

endmodule

bind matrix_3x3_inverse m3i_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_m3i_checker (.*);
